[sv/tpc_pkg.sv]
`timescale 1ns / 1ps
// Package: shared constants and types of the tone PWM parameter calculator.
package tpc_pkg;

   localparam int COUNTER_STEPS = 4096;
   localparam int STEP_SHIFT    = $clog2(COUNTER_STEPS);

   localparam int CLOCK_W = 28;
   localparam logic [CLOCK_W-1:0] CLOCK_RESET = 28'd125000000;

   localparam int TONE_W = 16;
   // ceil(clock / COUNTER_STEPS) width
   localparam int C1_W   = CLOCK_W + 1 - STEP_SHIFT;

   localparam int DIV_N_W     = 32;
   localparam int DIV_D_W     = 16;
   localparam int DIV_STEP    = 4;
   localparam int DIV_CNT_W   = $clog2(DIV_N_W / DIV_STEP);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(DIV_N_W / DIV_STEP - 1);

   localparam logic [DIV_D_W-1:0] DIV16_MIN = 16'd16;
   localparam logic [DIV_D_W-1:0] DIV16_MAX = 16'hFFFF;
   localparam logic [15:0]        WRAP_MAX  = 16'hFFFF;

   typedef struct packed {
      logic              channel;
      logic              silent;
      logic [TONE_W-1:0] tone_hz;
      logic [C1_W-1:0]   c1;
   } queue_entry_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] num;
      logic [DIV_D_W-1:0] den;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quo;
      logic [DIV_D_W-1:0] rem;
   } div_rsp_type;

endpackage

[sv/tpc_req_if.sv]
`timescale 1ns / 1ps
// Interface: request channel carrying channel and tone frequency.
interface tpc_req_if;
   logic        valid;
   logic        ready;
   logic        channel;
   logic [15:0] tone_hz;

   modport source (output valid, output channel, output tone_hz, input ready);
   modport sink   (input valid, input channel, input tone_hz, output ready);
endinterface

[sv/tpc_rsp_if.sv]
`timescale 1ns / 1ps
// Interface: result channel carrying the PWM settings.
interface tpc_rsp_if;
   logic        valid;
   logic        ready;
   logic        out_channel;
   logic        silent;
   logic [11:0] div_integer;
   logic [3:0]  div_fraction;
   logic [15:0] wrap_value;
   logic [14:0] compare_level;

   modport source (output valid, output out_channel, output silent, output div_integer,
                   output div_fraction, output wrap_value, output compare_level,
                   input ready);
   modport sink   (input valid, input out_channel, input silent, input div_integer,
                   input div_fraction, input wrap_value, input compare_level,
                   output ready);
endinterface

[sv/tpc_div.sv]
`timescale 1ns / 1ps
// Module: shared restoring divider, four quotient bits per cycle.
module tpc_div (
   input  logic                 clock,
   input  logic                 reset,
   input  tpc_pkg::div_req_type div_req,
   output tpc_pkg::div_rsp_type div_rsp
);

   logic [tpc_pkg::DIV_N_W-1:0]   num_ff, num_in;
   logic [tpc_pkg::DIV_D_W-1:0]   rem_ff, rem_in;
   logic [tpc_pkg::DIV_D_W-1:0]   den_ff, den_in;
   logic [tpc_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                          busy_ff, busy_in;
   logic                          done_ff, done_in;

   always_comb begin
      logic [tpc_pkg::DIV_D_W:0]   t;
      logic [tpc_pkg::DIV_D_W-1:0] r;
      logic [tpc_pkg::DIV_N_W-1:0] n;
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      r = rem_ff;
      n = num_ff;
      for (int i = 0; i < tpc_pkg::DIV_STEP; i++) begin
         t = {r, n[tpc_pkg::DIV_N_W-1]};
         n = {n[tpc_pkg::DIV_N_W-2:0], 1'b0};
         if (t >= {1'b0, den_ff}) begin
            t = t - {1'b0, den_ff};
            n[0] = 1'b1;
         end
         r = t[tpc_pkg::DIV_D_W-1:0];
      end
      if (div_req.start) begin
         num_in  = div_req.num;
         den_in  = div_req.den;
         rem_in  = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         num_in = n;
         rem_in = r;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == tpc_pkg::DIV_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done = done_ff;
   assign div_rsp.quo  = num_ff;
   assign div_rsp.rem  = rem_ff;

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff) else $error("divider started while busy");

endmodule

[sv/tpc_front.sv]
`timescale 1ns / 1ps
// Module: front end, takes requests, classifies silence, queues two entries.
module tpc_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tpc_pkg::CLOCK_W-1:0] clock_hz,
   tpc_req_if.sink                     req,
   output logic                        q_valid,
   input  logic                        q_ready,
   output tpc_pkg::queue_entry_type    q_entry
);

   tpc_pkg::queue_entry_type entry_ff [2];
   tpc_pkg::queue_entry_type entry_in;
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       push, pop;
   logic [tpc_pkg::CLOCK_W:0] clk_up;

   assign req.ready = (count_ff != 2'd2);
   assign push      = req.valid && req.ready;
   assign q_valid   = (count_ff != 2'd0);
   assign pop       = q_valid && q_ready;
   assign q_entry   = entry_ff[rd_ptr_ff];

   // ceil(clock / COUNTER_STEPS); the back end finishes the divider ceiling
   assign clk_up = {1'b0, clock_hz} + (tpc_pkg::CLOCK_W+1)'(tpc_pkg::COUNTER_STEPS - 1);

   always_comb begin
      entry_in.channel = req.channel;
      entry_in.silent  = (req.tone_hz == '0);
      entry_in.tone_hz = req.tone_hz;
      entry_in.c1      = clk_up[tpc_pkg::CLOCK_W:tpc_pkg::STEP_SHIFT];
      count_in         = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
      end
      if (push) entry_ff[wr_ptr_ff] <= entry_in;
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("request queue overfilled");

endmodule

[sv/tpc_back.sv]
`timescale 1ns / 1ps
// Module: back end, sequences the three divisions and holds the result register.
module tpc_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tpc_pkg::CLOCK_W-1:0] clock_hz,
   input  logic                        q_valid,
   output logic                        q_ready,
   input  tpc_pkg::queue_entry_type    q_entry,
   output tpc_pkg::div_req_type        div_req,
   input  tpc_pkg::div_rsp_type        div_rsp,
   tpc_rsp_if.source                   rsp
);

   typedef enum logic [4:0] {
      S_IDLE = 5'b00001,
      S_DIV1 = 5'b00010,
      S_DIV2 = 5'b00100,
      S_DIV3 = 5'b01000,
      S_OUT  = 5'b10000
   } state_type;

   state_type   state_ff, state_in;
   logic        ch_ff, ch_in;
   logic        silent_ff, silent_in;
   logic [15:0] tone_ff, tone_in;
   logic [15:0] div16_ff, div16_in;
   logic [15:0] wrap_ff, wrap_in;

   logic        out_valid_ff, out_valid_in;
   logic        out_ch_ff, out_silent_ff;
   logic [11:0] out_int_ff;
   logic [3:0]  out_frac_ff;
   logic [15:0] out_wrap_ff;
   logic [14:0] out_level_ff;
   logic        load;

   logic [tpc_pkg::DIV_N_W:0]   d_raw;
   logic [15:0]                 div16_sat;
   logic [tpc_pkg::DIV_N_W-1:0] quo_m1;

   // ceiling and clamp of the first quotient
   always_comb begin
      d_raw = {1'b0, div_rsp.quo} + (tpc_pkg::DIV_N_W+1)'(div_rsp.rem != '0);
      if (d_raw > (tpc_pkg::DIV_N_W+1)'(tpc_pkg::DIV16_MAX))
         div16_sat = tpc_pkg::DIV16_MAX;
      else if (d_raw < (tpc_pkg::DIV_N_W+1)'(tpc_pkg::DIV16_MIN))
         div16_sat = tpc_pkg::DIV16_MIN;
      else
         div16_sat = d_raw[15:0];
      quo_m1 = div_rsp.quo - 1'b1;
   end

   always_comb begin
      state_in      = state_ff;
      ch_in         = ch_ff;
      silent_in     = silent_ff;
      tone_in       = tone_ff;
      div16_in      = div16_ff;
      wrap_in       = wrap_ff;
      q_ready       = 1'b0;
      load          = 1'b0;
      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.den   = tone_ff;
      case (state_ff)
         S_IDLE: begin
            q_ready = 1'b1;
            if (q_valid) begin
               ch_in     = q_entry.channel;
               silent_in = q_entry.silent;
               tone_in   = q_entry.tone_hz;
               if (q_entry.silent) begin
                  div16_in = '0;
                  wrap_in  = '0;
                  state_in = S_OUT;
               end else begin
                  div_req.start = 1'b1;
                  div_req.num   = tpc_pkg::DIV_N_W'(q_entry.c1);
                  div_req.den   = q_entry.tone_hz;
                  state_in      = S_DIV1;
               end
            end
         end
         S_DIV1: begin
            if (div_rsp.done) begin
               div16_in      = div16_sat;
               div_req.start = 1'b1;
               div_req.num   = {clock_hz, 4'b0000};
               div_req.den   = div16_sat;
               state_in      = S_DIV2;
            end
         end
         S_DIV2: begin
            if (div_rsp.done) begin
               div_req.start = 1'b1;
               div_req.num   = div_rsp.quo;
               div_req.den   = tone_ff;
               state_in      = S_DIV3;
            end
         end
         S_DIV3: begin
            if (div_rsp.done) begin
               if (div_rsp.quo == '0)
                  wrap_in = '0;
               else if (quo_m1 > tpc_pkg::DIV_N_W'(tpc_pkg::WRAP_MAX))
                  wrap_in = tpc_pkg::WRAP_MAX;
               else
                  wrap_in = quo_m1[15:0];
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!out_valid_ff || rsp.ready) begin
               load     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      out_valid_in = load || (out_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      ch_ff     <= ch_in;
      silent_ff <= silent_in;
      tone_ff   <= tone_in;
      div16_ff  <= div16_in;
      wrap_ff   <= wrap_in;
      if (load) begin
         out_ch_ff     <= ch_ff;
         out_silent_ff <= silent_ff;
         out_int_ff    <= div16_ff[15:4];
         out_frac_ff   <= div16_ff[3:0];
         out_wrap_ff   <= wrap_ff;
         out_level_ff  <= wrap_ff[15:1];
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.out_channel   = out_ch_ff;
   assign rsp.silent        = out_silent_ff;
   assign rsp.div_integer   = out_int_ff;
   assign rsp.div_fraction  = out_frac_ff;
   assign rsp.wrap_value    = out_wrap_ff;
   assign rsp.compare_level = out_level_ff;

   a_silent_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_silent_ff) |->
         (out_wrap_ff == '0 && out_int_ff == '0 && out_frac_ff == '0))
      else $error("silent result with nonzero settings");

   a_level_half: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_level_ff == out_wrap_ff[15:1]))
      else $error("compare level not half of wrap");

   a_div3_out: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV3 && div_rsp.done) |=> state_ff == S_OUT)
      else $error("last division did not finish the item");

endmodule

[sv/tone_pwm_parameter_calc_core.sv]
`timescale 1ns / 1ps
// Top level: tone PWM parameter calculator core.
//
// Usage: a request on req_port carries a buzzer channel and a tone in hertz.
// One result per request appears on rsp_port: integer and fractional clock
// divider, counter wrap and the 50% compare level. A tone of 0 gives a silent
// result with all settings zero. csr_wr_en/csr_wr_data set the system clock
// in hertz; write it only while no request is in flight.
//
// Timing: a tone passes the queue, three divisions on the shared
// 4-bit-per-cycle divider and the result register; silence passes only the
// queue and the result register. The back end takes one request at a time
// from the queue, the next only after the previous result is loaded. The
// front queue holds two requests, so req_port keeps accepting while the back
// end divides and while a result waits.
//
// Reset: clock_hz returns to 125 MHz, queue and result register empty.
// Stall: while rsp_port.ready is low the result holds; the back end then
// stops and the queue fills, after which req_port.ready drops.
module tone_pwm_parameter_calc_core (
   input  logic                        clock,
   input  logic                        reset,
   tpc_req_if.sink                     req_port,
   tpc_rsp_if.source                   rsp_port,
   input  logic                        csr_wr_en,
   input  logic [tpc_pkg::CLOCK_W-1:0] csr_wr_data
);

   logic [tpc_pkg::CLOCK_W-1:0] clock_hz_ff;
   logic                        q_valid, q_ready;
   tpc_pkg::queue_entry_type    q_entry;
   tpc_pkg::div_req_type        div_req;
   tpc_pkg::div_rsp_type        div_rsp;

   // system clock setting
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff <= tpc_pkg::CLOCK_RESET;
      end else if (csr_wr_en) begin
         clock_hz_ff <= csr_wr_data;
      end
   end

   // front: accept and classify
   tpc_front u_front (
      .clock    (clock),
      .reset    (reset),
      .clock_hz (clock_hz_ff),
      .req      (req_port),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_entry  (q_entry)
   );

   // back: divider sequencing and result register
   tpc_back u_back (
      .clock    (clock),
      .reset    (reset),
      .clock_hz (clock_hz_ff),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_entry  (q_entry),
      .div_req  (div_req),
      .div_rsp  (div_rsp),
      .rsp      (rsp_port)
   );

   tpc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

endmodule
